FILE: hw/rtl/fcfl_pkg.sv
// Shared types, codes and constants of the fixed chunk free list pool.
package fcfl_pkg;

   // Default sizing of the pool.
   localparam int MaxBlocksDef         = 8;
   localparam int MaxChunksPerBlockDef = 64;

   // Link header placed in front of every chunk payload.
   localparam int HeaderBytes = 8;

   // Fixed field widths.
   localparam int HandleW     = 9;
   localparam int DataSizeW   = 16;
   localparam int CpbW        = 7;
   localparam int OffsetW     = 25;
   localparam int BlocksOutW  = 4;
   localparam int CsrIndexW   = 2;
   localparam int CsrDataW    = 16;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_GROW   = 2'd1,
      STATUS_LIMIT     = 2'd2,
      STATUS_NULL_FREE = 2'd3
   } status_type;

   // Request kinds.
   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   // Configuration register indexes.
   typedef enum logic [CsrIndexW-1:0] {
      CSR_DATA_SIZE        = 2'd0,
      CSR_CHUNKS_PER_BLOCK = 2'd1,
      CSR_ALLOW_GROW       = 2'd2,
      CSR_START_WITH_BLOCK = 2'd3
   } csr_index_type;

   // One request beat.
   typedef struct packed {
      req_kind_type          req_type;
      logic [HandleW-1:0]    handle;
      logic                  handle_present;
   } req_payload_type;

   // One response beat.
   typedef struct packed {
      status_type              status;
      logic [HandleW-1:0]      chunk_index;
      logic [OffsetW-1:0]      byte_offset;
      logic [BlocksOutW-1:0]   blocks_in_use;
   } rsp_payload_type;

endpackage

FILE: hw/rtl/fixed_chunk_free_list_pool_unit.sv
// Fixed-size chunk pool: free list of chunk indexes kept in a link memory.
// A free or a refused allocate answers in the cycle after start; an allocate from a
// non-empty list goes through ST_POP, one that adds a block through ST_GROW (one link
// written per cycle). A free can be taken every cycle; an allocate holds busy until it
// ends. Synchronous reset empties the list, clears the block count and reloads the
// registers; the link memory keeps its contents. The receiver cannot stall results.
module fixed_chunk_free_list_pool_unit
   import fcfl_pkg::*;
#(
   parameter int MAX_BLOCKS           = MaxBlocksDef,
   parameter int MAX_CHUNKS_PER_BLOCK = MaxChunksPerBlockDef
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port.
   input  logic                  csr_we,
   input  logic [CsrIndexW-1:0]  csr_index,
   input  logic [CsrDataW-1:0]   csr_wdata,
   // Request channel.
   input  logic                  start,
   input  req_payload_type       req_data,
   output logic                  busy,
   // Response channel.
   output logic                  rsp_valid,
   output rsp_payload_type       rsp_data
);

   localparam int PoolSlots = MAX_BLOCKS * MAX_CHUNKS_PER_BLOCK;
   localparam int SlotW     = (PoolSlots > 1) ? $clog2(PoolSlots) : 1;
   localparam int CntW      = $clog2(PoolSlots + 1);
   localparam int LenW      = $clog2(MAX_CHUNKS_PER_BLOCK + 1);
   localparam int BlkW      = $clog2(MAX_BLOCKS + 1);
   localparam int LinkW     = SlotW + 1;
   localparam int MulW      = DataSizeW + 1;
   localparam int ProdW     = SlotW + MulW;
   localparam int SumW      = (ProdW + 1 > OffsetW) ? ProdW + 1 : OffsetW;
   localparam int IdxExtW   = (SlotW > HandleW) ? SlotW : HandleW;
   localparam int BlkExtW   = (BlkW > BlocksOutW) ? BlkW : BlocksOutW;
   localparam int ClampW    = (LenW > CpbW) ? LenW : CpbW;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_POP  = 3'b010,
      ST_GROW = 3'b100
   } state_type;

   // Configuration registers.
   logic [DataSizeW-1:0]  data_size_ff;
   logic [CpbW-1:0]       cpb_ff;
   logic                  allow_grow_ff;
   logic                  start_block_ff;

   // Control state.
   state_type             state_ff,    state_in;
   logic [LinkW-1:0]      head_ff,     head_in;
   logic [BlkW-1:0]       blocks_ff,   blocks_in;
   logic [CntW-1:0]       chunks_ff,   chunks_in;
   logic [LenW-1:0]       grow_cnt_ff, grow_cnt_in;
   logic [LenW-1:0]       len_ff,      len_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [SlotW-1:0]      idx_ff,  idx_in;
   logic [ProdW-1:0]      prod_ff, prod_in;
   rsp_payload_type       rsp_ff,  rsp_in;

   // Link memory: {valid, next index} per chunk.
   logic [LinkW-1:0]      link_mem [PoolSlots];
   logic [LinkW-1:0]      rd_link_ff;
   logic                  mem_we;
   logic [SlotW-1:0]      mem_waddr;
   logic [LinkW-1:0]      mem_wdata;

   logic                  accept;
   logic [LenW-1:0]       blk_len;
   logic [ClampW-1:0]     cpb_ext;
   logic                  grow_permitted;
   logic                  grow_limited;
   logic                  handle_ok;
   logic [SlotW-1:0]      grow_addr;
   logic                  grow_last;
   logic [SlotW-1:0]      mul_idx;
   logic [MulW-1:0]       chunk_stride;
   logic [SumW-1:0]       offset_sum;
   logic [IdxExtW-1:0]    idx_ext;
   logic [BlkExtW-1:0]    blocks_ext;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Chunks per block clamped to the range the pool supports.
   assign cpb_ext = ClampW'(cpb_ff);
   always_comb begin
      if (cpb_ff == '0) begin
         blk_len = LenW'(1);
      end else if (cpb_ext > ClampW'(MAX_CHUNKS_PER_BLOCK)) begin
         blk_len = LenW'(MAX_CHUNKS_PER_BLOCK);
      end else begin
         blk_len = LenW'(cpb_ext);
      end
   end

   // Growth permission and limit checks on an empty list.
   assign grow_permitted = allow_grow_ff || ((blocks_ff == '0) && start_block_ff);
   assign grow_limited   = (int'(blocks_ff) >= MAX_BLOCKS) ||
                           ((int'(chunks_ff) + int'(blk_len)) > PoolSlots);
   assign handle_ok      = req_data.handle_present && (int'(req_data.handle) < PoolSlots);

   // Link written for the current chunk of a block growth.
   assign grow_addr = SlotW'(chunks_ff + CntW'(grow_cnt_ff));
   assign grow_last = ((grow_cnt_ff + LenW'(1)) == len_ff);

   // Chunk stride and the multiplier operand chosen at accept.
   assign chunk_stride = MulW'(data_size_ff) + MulW'(HeaderBytes);
   assign mul_idx      = head_ff[LinkW-1] ? head_ff[SlotW-1:0] : SlotW'(chunks_ff);

   // Offset and index of the registered product for the result beat.
   assign offset_sum = SumW'(prod_ff) + SumW'(HeaderBytes);
   assign idx_ext    = IdxExtW'(idx_ff);
   assign blocks_ext = BlkExtW'(blocks_ff);

   // Next-state logic for requests, growth and results.
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      blocks_in    = blocks_ff;
      chunks_in    = chunks_ff;
      grow_cnt_in  = grow_cnt_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = grow_addr;
      mem_wdata    = {~grow_last, grow_addr + SlotW'(1)};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.chunk_index   = '0;
               rsp_in.byte_offset   = '0;
               rsp_in.blocks_in_use = blocks_ext[BlocksOutW-1:0];
               idx_in  = mul_idx;
               prod_in = ProdW'(mul_idx) * ProdW'(chunk_stride);
               if (req_data.req_type == REQ_FREE) begin
                  // A free pushes its chunk onto the head.
                  rsp_valid_in = 1'b1;
                  if (handle_ok) begin
                     rsp_in.status = STATUS_OK;
                     mem_we    = 1'b1;
                     mem_waddr = SlotW'(req_data.handle);
                     mem_wdata = head_ff;
                     head_in   = {1'b1, SlotW'(req_data.handle)};
                  end else begin
                     rsp_in.status = STATUS_NULL_FREE;
                  end
               end else if (head_ff[LinkW-1]) begin
                  state_in = ST_POP;
               end else if (!grow_permitted) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_NO_GROW;
               end else if (grow_limited) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = STATUS_LIMIT;
               end else begin
                  state_in    = ST_GROW;
                  grow_cnt_in = '0;
                  len_in      = blk_len;
               end
            end
         end
         ST_POP: begin
            // The head's link arrived from memory: it becomes the new head.
            head_in              = rd_link_ff;
            state_in             = ST_IDLE;
            rsp_valid_in         = 1'b1;
            rsp_in.status        = STATUS_OK;
            rsp_in.chunk_index   = idx_ext[HandleW-1:0];
            rsp_in.byte_offset   = offset_sum[OffsetW-1:0];
            rsp_in.blocks_in_use = blocks_ext[BlocksOutW-1:0];
         end
         ST_GROW: begin
            // Link the new block in ascending order, one entry a cycle.
            mem_we      = 1'b1;
            grow_cnt_in = grow_cnt_ff + LenW'(1);
            if (grow_last) begin
               head_in              = {(len_ff > LenW'(1)), SlotW'(chunks_ff) + SlotW'(1)};
               chunks_in            = chunks_ff + CntW'(len_ff);
               blocks_in            = blocks_ff + BlkW'(1);
               state_in             = ST_IDLE;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = STATUS_OK;
               rsp_in.chunk_index   = idx_ext[HandleW-1:0];
               rsp_in.byte_offset   = offset_sum[OffsetW-1:0];
               rsp_in.blocks_in_use = BlocksOutW'(blocks_ff + BlkW'(1));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         data_size_ff   <= DataSizeW'(64);
         cpb_ff         <= CpbW'(64);
         allow_grow_ff  <= 1'b1;
         start_block_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DATA_SIZE:        data_size_ff   <= csr_wdata;
            CSR_CHUNKS_PER_BLOCK: cpb_ff         <= csr_wdata[CpbW-1:0];
            CSR_ALLOW_GROW:       allow_grow_ff  <= csr_wdata[0];
            CSR_START_WITH_BLOCK: start_block_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         blocks_ff    <= '0;
         chunks_ff    <= '0;
         grow_cnt_ff  <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         blocks_ff    <= blocks_in;
         chunks_ff    <= chunks_in;
         grow_cnt_ff  <= grow_cnt_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   // Link memory: one write port, one registered read of the head's link.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_link_ff <= link_mem[head_ff[SlotW-1:0]];
      end
   end

`ifndef ASSERT_OFF
   // A response beat only follows an accepted request or finished work.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(start) && !$past(busy)) || ($past(state_ff) != ST_IDLE))
      else $error("response beat without a request");

   // Growth never writes past the end of the link memory.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GROW) |-> ((int'(chunks_ff) + int'(grow_cnt_ff)) < PoolSlots))
      else $error("block growth outside the link memory");

   // The block count stays within the pool limit.
   assert property (@(posedge clock) disable iff (reset)
      int'(blocks_ff) <= MAX_BLOCKS)
      else $error("block count above limit");

   // Refused allocates and refused frees carry no chunk.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |->
         (rsp_data.chunk_index == '0) && (rsp_data.byte_offset == '0))
      else $error("refused response carries a chunk");

   // A finished growth of more than one chunk leaves the list non-empty.
   assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == ST_GROW) && (state_ff == ST_IDLE) && ($past(len_ff) > LenW'(1))
         |-> head_ff[LinkW-1])
      else $error("growth left the free list empty");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the fixed chunk free list pool unit.
module testbench;
   import fcfl_pkg::*;

   localparam int PoolSlots  = MaxBlocksDef * MaxChunksPerBlockDef;
   localparam int CycleLimit = 1000000;
   localparam int DrainTail  = MaxChunksPerBlockDef + 8;

   // Clock, reset and block inputs, all known from time zero.
   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            csr_we    = 1'b0;
   csr_index_type   csr_index = CSR_DATA_SIZE;
   logic [15:0]     csr_wdata = '0;
   logic            start     = 1'b0;
   req_payload_type req_data  = '0;
   logic            busy;
   logic            rsp_valid;
   rsp_payload_type rsp_data;

   // Shadow copy of the pool registers.
   logic [15:0] cfg_data_size;
   logic [6:0]  cfg_chunks_per_block;
   logic        cfg_allow_grow;
   logic        cfg_start_block;

   // Shadow copy of the pool state.
   int unsigned pool_head;
   bit          pool_head_ok;
   int unsigned pool_link [PoolSlots];
   bit          pool_link_ok [PoolSlots];
   bit          chunk_listed [PoolSlots];
   int unsigned pool_blocks;
   int unsigned pool_chunks;

   // Answers still owed by the block, and chunks the sender currently holds.
   rsp_payload_type answers_due [$];
   logic [8:0]      held_chunks [$];

   int error_count = 0;
   int cycles = 0;
   bit sender_idles = 1'b1;

   fixed_chunk_free_list_pool_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, period 12.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Work out the answer to one request and update the shadow pool.
   function automatic rsp_payload_type predict_answer(req_payload_type rq);
      rsp_payload_type ans;
      status_type      st;
      int unsigned     n;
      int unsigned     idx;
      logic [31:0]     ofs;
      bit              permitted;
      st  = STATUS_OK;
      idx = 0;
      ofs = '0;
      n = cfg_chunks_per_block;
      if (n == 0) n = 1;
      if (n > MaxChunksPerBlockDef) n = MaxChunksPerBlockDef;
      if (rq.req_type == REQ_ALLOC) begin
         // An empty list tries to add a fresh block first.
         if (!pool_head_ok) begin
            permitted = cfg_allow_grow || (pool_blocks == 0 && cfg_start_block);
            if (!permitted) begin
               st = STATUS_NO_GROW;
            end else if (pool_blocks >= MaxBlocksDef || pool_chunks + n > PoolSlots) begin
               st = STATUS_LIMIT;
            end else begin
               for (int i = 0; i < n; i++) begin
                  pool_link[pool_chunks + i]    = pool_chunks + i + 1;
                  pool_link_ok[pool_chunks + i] = (i + 1 < n);
                  chunk_listed[pool_chunks + i] = 1'b1;
               end
               pool_head    = pool_chunks;
               pool_head_ok = 1'b1;
               pool_chunks += n;
               pool_blocks += 1;
            end
         end
         // Pop the head.
         if (st == STATUS_OK && pool_head_ok && pool_head < PoolSlots) begin
            idx               = pool_head;
            pool_head_ok      = pool_link_ok[idx];
            pool_head         = pool_link[idx];
            chunk_listed[idx] = 1'b0;
            ofs = idx * (cfg_data_size + HeaderBytes) + HeaderBytes;
         end else if (st == STATUS_OK) begin
            st = STATUS_NO_GROW;
         end
      end else begin
         // A free with a null handle is ignored; otherwise push onto the head.
         if (!rq.handle_present || rq.handle >= PoolSlots) begin
            st = STATUS_NULL_FREE;
         end else begin
            pool_link[rq.handle]    = pool_head;
            pool_link_ok[rq.handle] = pool_head_ok;
            chunk_listed[rq.handle] = 1'b1;
            pool_head               = rq.handle;
            pool_head_ok            = 1'b1;
         end
      end
      ans.status        = st;
      ans.chunk_index   = idx[8:0];
      ans.byte_offset   = ofs[24:0];
      ans.blocks_in_use = pool_blocks[3:0];
      return ans;
   endfunction

   // One line per mismatch; printing stops after a hundred of them.
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      error_count++;
      if (error_count <= 100)
         $display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, want);
   endtask

   // Send one request beat and record what it should produce.
   task automatic send_req(req_kind_type kind, logic [8:0] h, logic hp,
                           output rsp_payload_type ans);
      req_payload_type rq;
      int              pos [$];
      rq.req_type       = kind;
      rq.handle         = h;
      rq.handle_present = hp;
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      ans = predict_answer(rq);
      answers_due.push_back(ans);
      if (kind == REQ_ALLOC && ans.status == STATUS_OK) begin
         held_chunks.push_back(ans.chunk_index);
      end else if (kind == REQ_FREE && ans.status == STATUS_OK) begin
         pos = held_chunks.find_first_index(c) with (c == h);
         if (pos.size() != 0) held_chunks.delete(pos[0]);
      end
      // Random gap after the beat.
      if (sender_idles && $urandom_range(0, 99) < 29) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every owed answer has come back.
   task automatic drain_answers();
      start <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers while the block is idle.
   task automatic configure(logic [15:0] ds, logic [15:0] cpb, logic [15:0] ag,
                            logic [15:0] sb);
      logic [15:0] vals [4];
      drain_answers();
      vals = '{ds, cpb, ag, sb};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
         case (csr_index_type'(i))
            CSR_DATA_SIZE:        cfg_data_size        = vals[i];
            CSR_CHUNKS_PER_BLOCK: cfg_chunks_per_block = vals[i][6:0];
            CSR_ALLOW_GROW:       cfg_allow_grow       = vals[i][0];
            CSR_START_WITH_BLOCK: cfg_start_block      = vals[i][0];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   // Compare each response beat with the oldest owed answer.
   always @(posedge clock) begin : check_rsp
      rsp_payload_type want_beat;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            report_mismatch("response with nothing owed", rsp_data, 0);
         end else begin
            want_beat = answers_due.pop_front();
            if (rsp_data.status !== want_beat.status)
               report_mismatch("status", rsp_data.status, want_beat.status);
            if (rsp_data.chunk_index !== want_beat.chunk_index)
               report_mismatch("chunk_index", rsp_data.chunk_index, want_beat.chunk_index);
            if (rsp_data.byte_offset !== want_beat.byte_offset)
               report_mismatch("byte_offset", rsp_data.byte_offset, want_beat.byte_offset);
            if (rsp_data.blocks_in_use !== want_beat.blocks_in_use)
               report_mismatch("blocks_in_use", rsp_data.blocks_in_use,
                               want_beat.blocks_in_use);
         end
      end
   end

   // Growth permission: none, first block only, clamped block sizes.
   task automatic test_growth_rules();
      rsp_payload_type ans;
      configure(16'd1, 16'd2, 16'd0, 16'd0);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
      configure(16'd1, 16'd2, 16'd0, 16'd1);
      send_req(REQ_ALLOC, 9'd511, 1'b1, ans);
      send_req(REQ_ALLOC, 9'd0, 1'b1, ans);
      send_req(REQ_ALLOC, 9'd511, 1'b0, ans);
      // A zero block size counts as one chunk.
      configure(16'd65535, 16'd0, 16'd1, 16'd0);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
      // Oversized blocks are clamped to the largest block.
      configure(16'd65535, 16'd127, 16'd1, 16'd0);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
   endtask

   // Null frees, a free of a held chunk and a free of a chunk never handed out.
   task automatic test_free_cases();
      rsp_payload_type ans;
      send_req(REQ_FREE, 9'd511, 1'b0, ans);
      send_req(REQ_FREE, 9'd0, 1'b0, ans);
      send_req(REQ_FREE, 9'd1, 1'b1, ans);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
      send_req(REQ_FREE, 9'd300, 1'b1, ans);
      send_req(REQ_ALLOC, 9'd300, 1'b1, ans);
   endtask

   // Smallest and largest payload offsets.
   task automatic test_offset_extremes();
      rsp_payload_type ans;
      configure(16'd65535, 16'd64, 16'd1, 16'd1);
      send_req(REQ_FREE, 9'd511, 1'b1, ans);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
      configure(16'd1, 16'd64, 16'd1, 16'd1);
      send_req(REQ_FREE, 9'd0, 1'b1, ans);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
   endtask

   // Random traffic: allocates, frees of held chunks and noise, over several settings.
   task automatic test_random();
      rsp_payload_type ans;
      logic [15:0]     ds;
      logic [6:0]      cpb;
      logic [8:0]      h;
      int              alloc_pct;
      int              pick;
      for (int phase = 0; phase < 5; phase++) begin
         case ($urandom_range(0, 3))
            0:       ds = 16'd1;
            1:       ds = 16'd65535;
            default: ds = 16'($urandom_range(1, 65535));
         endcase
         case ($urandom_range(0, 7))
            0:       cpb = 7'd0;
            1:       cpb = 7'd1;
            2:       cpb = 7'd3;
            3:       cpb = 7'd64;
            4:       cpb = 7'd127;
            default: cpb = 7'($urandom_range(2, 20));
         endcase
         configure(ds, {7'($urandom), 2'b00, cpb},
                   16'($urandom_range(0, 65535)) | ((phase == 0) ? 16'd1 : 16'd0),
                   16'($urandom_range(0, 65535)));
         sender_idles = (phase != 2);
         alloc_pct = $urandom_range(35, 70);
         for (int k = 0; k < 200; k++) begin
            // In phase 3, pause once midway until everything owed has arrived.
            if (phase == 3 && k == 100) drain_answers();
            if ($urandom_range(0, 99) < alloc_pct) begin
               send_req(REQ_ALLOC, 9'($urandom), 1'($urandom), ans);
            end else if (held_chunks.size() != 0 && $urandom_range(0, 99) < 85) begin
               pick = $urandom_range(0, held_chunks.size() - 1);
               send_req(REQ_FREE, held_chunks[pick], 1'b1, ans);
            end else begin
               // A listed chunk is sent as a null free so the list stays acyclic.
               h = 9'($urandom);
               send_req(REQ_FREE, h, chunk_listed[h] ? 1'b0 : 1'($urandom), ans);
            end
         end
      end
      sender_idles = 1'b1;
   endtask

   // Allocate until growth runs out of blocks, then with growth disabled.
   task automatic test_block_limit();
      rsp_payload_type ans;
      int              tries;
      configure(16'd8, 16'd1, 16'd1, 16'd1);
      tries = 0;
      do begin
         send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
         tries++;
      end while (ans.status == STATUS_OK && tries < 700);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
      configure(16'd8, 16'd1, 16'd0, 16'd1);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
   endtask

   // The same chunk freed twice is handed out again each time; no check is made.
   task automatic test_double_free();
      rsp_payload_type ans;
      logic [8:0]      h;
      configure(16'd100, 16'd4, 16'd1, 16'd1);
      h = (held_chunks.size() != 0) ? held_chunks[0] : 9'd5;
      send_req(REQ_FREE, h, 1'b1, ans);
      send_req(REQ_FREE, h, 1'b1, ans);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
      send_req(REQ_ALLOC, 9'd0, 1'b0, ans);
   endtask

   // Run limit.
   initial begin : watchdog
      for (cycles = 0; cycles < CycleLimit; cycles++) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Reset, then the tests in turn, then the final verdict.
   initial begin
      cfg_data_size        = 16'd64;
      cfg_chunks_per_block = 7'd64;
      cfg_allow_grow       = 1'b1;
      cfg_start_block      = 1'b1;
      pool_head            = 0;
      pool_head_ok         = 1'b0;
      pool_blocks          = 0;
      pool_chunks          = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_growth_rules();
      test_free_cases();
      test_offset_extremes();
      test_random();
      test_block_limit();
      test_double_free();
      drain_answers();
      repeat (DrainTail) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
